// ----- rtl/sitoa_pkg.sv -----
// Shared types and constants for the signed integer to decimal text converter.
// No dependencies; used by the interfaces, controller, datapath and top level.
`default_nettype none

package sitoa_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int MAX_DIGITS = 10;
  localparam int CNT_W      = 4;
  localparam int PROD_W     = 2 * VALUE_W;

  // floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every 32-bit unsigned x
  localparam logic [VALUE_W-1:0] RECIP       = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;
  localparam int                 QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam logic [DIGIT_W-1:0] DIGIT_BASE = 4'd10;
  localparam logic [CHAR_W-1:0]  MINUS_CHAR = 8'd45;
  localparam logic [CHAR_W-1:0]  ZERO_CHAR  = 8'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_REM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic rem;
    logic emit;
    logic pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic digits_done;
    logic char_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/sitoa_ifs.sv -----
// Valid/ready channel interfaces: integer input and character output.
// Depends on sitoa_pkg for payload widths.
`default_nettype none

interface sitoa_num_if;
  logic                                valid;
  logic                                ready;
  logic signed [sitoa_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitoa_text_if;
  logic                        valid;
  logic                        ready;
  logic [sitoa_pkg::CHAR_W-1:0] character;
  logic                        last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/signed_int_to_decimal_ascii_top.sv -----
// Signed 32-bit integer to decimal ASCII text converter, top level.
// Depends on sitoa_pkg, sitoa_ifs, sitoa_ctrl and sitoa_datapath.
//
// Usage:
//   num  (sink):   one signed 32-bit value per transfer.
//   text (source): one ASCII byte per transfer, most significant first,
//                  '-' ahead of negative values, no leading zeros,
//                  last = 1 on the final character of each number.
// Timing:
//   The value is taken in the idle state. Digits come from a reciprocal
//   multiply by 1/10 followed by a remainder step, in states ST_MUL and
//   ST_REM for each digit. Characters then leave one per cycle while
//   text.ready is high. num.ready is low from acceptance until the last
//   character transfers.
// Stall:
//   While text.ready is low the current character holds; nothing is lost.
// Reset:
//   Synchronous rst returns to idle; a partly sent number is dropped.
`default_nettype none

module signed_int_to_decimal_ascii_top (
  input  wire         clk,
  input  wire         rst,
  sitoa_num_if.sink   num,
  sitoa_text_if.source text
);

  sitoa_pkg::ctrl_cmd_t  cmd;
  sitoa_pkg::dp_status_t status;

  sitoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (num.valid),
    .out_ready (text.ready),
    .status    (status),
    .in_ready  (num.ready),
    .out_valid (text.valid),
    .cmd       (cmd)
  );

  sitoa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (num.value),
    .status    (status),
    .character (text.character),
    .last      (text.last)
  );

endmodule

`default_nettype wire

// ----- rtl/sitoa_ctrl.sv -----
// Sequencer for the converter: accept, divide loop, character emission.
// Depends on sitoa_pkg for state, command and status types.
`default_nettype none

module sitoa_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  input  wire                   out_ready,
  input  sitoa_pkg::dp_status_t status,
  output logic                  in_ready,
  output logic                  out_valid,
  output sitoa_pkg::ctrl_cmd_t  cmd
);

  sitoa_pkg::state_t state;
  sitoa_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sitoa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sitoa_pkg::ST_IDLE: begin
        if (in_valid) state_next = sitoa_pkg::ST_MUL;
      end
      sitoa_pkg::ST_MUL: begin
        state_next = sitoa_pkg::ST_REM;
      end
      sitoa_pkg::ST_REM: begin
        state_next = status.digits_done ? sitoa_pkg::ST_EMIT : sitoa_pkg::ST_MUL;
      end
      sitoa_pkg::ST_EMIT: begin
        if (out_ready && status.char_last) state_next = sitoa_pkg::ST_IDLE;
      end
      default: state_next = sitoa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state)
      sitoa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sitoa_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      sitoa_pkg::ST_REM: begin
        cmd.rem = 1'b1;
      end
      sitoa_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        cmd.emit  = 1'b1;
        cmd.pop   = out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/sitoa_datapath.sv -----
// Datapath: magnitude, reciprocal divide by ten, digit stack, character mux.
// Depends on sitoa_pkg for widths, constants and command/status types.
`default_nettype none

module sitoa_datapath (
  input  wire                                  clk,
  input  wire                                  rst,
  input  sitoa_pkg::ctrl_cmd_t                 cmd,
  input  wire signed [sitoa_pkg::VALUE_W-1:0]  value,
  output sitoa_pkg::dp_status_t                status,
  output logic [sitoa_pkg::CHAR_W-1:0]         character,
  output logic                                 last
);

  logic [sitoa_pkg::VALUE_W-1:0] mag;
  logic [sitoa_pkg::PROD_W-1:0]  prod;
  logic                          neg_pending;
  logic [sitoa_pkg::CNT_W-1:0]   ndig;
  logic [sitoa_pkg::DIGIT_W-1:0] digits [sitoa_pkg::MAX_DIGITS];

  logic [sitoa_pkg::QUOT_W-1:0]  quot;
  logic [sitoa_pkg::VALUE_W-1:0] quot_x10;
  logic [sitoa_pkg::VALUE_W-1:0] rem_full;
  logic [sitoa_pkg::DIGIT_W-1:0] rem_digit;

  assign quot      = prod[sitoa_pkg::PROD_W-1:sitoa_pkg::RECIP_SHIFT];
  assign quot_x10  = ({{(sitoa_pkg::VALUE_W-sitoa_pkg::QUOT_W){1'b0}}, quot} << 3)
                   + ({{(sitoa_pkg::VALUE_W-sitoa_pkg::QUOT_W){1'b0}}, quot} << 1);
  assign rem_full  = mag - quot_x10;
  assign rem_digit = rem_full[sitoa_pkg::DIGIT_W-1:0];

  assign status.digits_done = (quot == '0)
                            || (ndig == sitoa_pkg::CNT_W'(sitoa_pkg::MAX_DIGITS - 1));
  assign status.char_last   = !neg_pending && (ndig == sitoa_pkg::CNT_W'(1));

  assign character = neg_pending ? sitoa_pkg::MINUS_CHAR
                                 : sitoa_pkg::ZERO_CHAR
                                   + {{(sitoa_pkg::CHAR_W-sitoa_pkg::DIGIT_W){1'b0}},
                                      digits[0]};
  assign last      = status.char_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      neg_pending <= 1'b0;
      ndig        <= '0;
    end else if (cmd.load) begin
      neg_pending <= value[sitoa_pkg::VALUE_W-1];
      ndig        <= '0;
    end else if (cmd.rem) begin
      ndig <= ndig + sitoa_pkg::CNT_W'(1);
    end else if (cmd.pop) begin
      if (neg_pending) begin
        neg_pending <= 1'b0;
      end else begin
        ndig <= ndig - sitoa_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= value[sitoa_pkg::VALUE_W-1] ? (~value + sitoa_pkg::VALUE_W'(1))
                                         : value;
    end else if (cmd.rem) begin
      mag <= {{(sitoa_pkg::VALUE_W-sitoa_pkg::QUOT_W){1'b0}}, quot};
    end
    if (cmd.mul) begin
      prod <= {{sitoa_pkg::VALUE_W{1'b0}}, mag}
            * {{sitoa_pkg::VALUE_W{1'b0}}, sitoa_pkg::RECIP};
    end
  end

  // LIFO: push at index 0 shifting up, pop shifting down; top is most significant
  always_ff @(posedge clk) begin
    if (cmd.rem) begin
      digits[0] <= rem_digit;
      for (int i = 1; i < sitoa_pkg::MAX_DIGITS; i++) begin
        digits[i] <= digits[i-1];
      end
    end else if (cmd.pop && !neg_pending) begin
      for (int i = 0; i < sitoa_pkg::MAX_DIGITS - 1; i++) begin
        digits[i] <= digits[i+1];
      end
    end
  end

  a_rem_is_digit: assert property (@(posedge clk) disable iff (rst)
    cmd.rem |-> (rem_full < {{(sitoa_pkg::VALUE_W-sitoa_pkg::DIGIT_W){1'b0}},
                             sitoa_pkg::DIGIT_BASE}))
    else $error("remainder out of digit range");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (ndig != '0) && (ndig <= sitoa_pkg::CNT_W'(sitoa_pkg::MAX_DIGITS)))
    else $error("emitting with empty or overfull digit stack");

  a_pop_counts_down: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop && !neg_pending) |=> (ndig == $past(ndig) - sitoa_pkg::CNT_W'(1)))
    else $error("digit count did not follow pop");

  a_sign_first: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && neg_pending) |-> (character == sitoa_pkg::MINUS_CHAR) && !last)
    else $error("sign character misplaced");

endmodule

`default_nettype wire
